FILE: rtl/bcr_pkg.sv
package bcr_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int FRAC_BITS   = 12;
  localparam int OUT_BITS    = SAMPLE_BITS + 3;
  // headroom for the cubic coefficients and the horner sums
  localparam int ACC_BITS    = OUT_BITS + 7;
  localparam int PROD_BITS   = ACC_BITS + FRAC_BITS + 1;
  localparam int COLS        = 4;
  localparam int IDX_BITS    = $clog2(COLS);

  typedef struct packed {
    logic                load_in;
    logic                load_part;
    logic                coef;
    logic                mul;
    logic                add_b;
    logic                add_c;
    logic                store_part;
    logic                write_out;
    logic [IDX_BITS-1:0] part_idx;
  } bcr_cmd_t;

  typedef struct packed {
    logic out_full;
  } bcr_sts_t;

endpackage

FILE: rtl/bcr_if.sv
interface bcr_in_if;
  logic                             valid;
  logic                             ready;
  logic [bcr_pkg::SAMPLE_BITS-1:0] sample_row0;
  logic [bcr_pkg::SAMPLE_BITS-1:0] sample_row1;
  logic [bcr_pkg::SAMPLE_BITS-1:0] sample_row2;
  logic [bcr_pkg::SAMPLE_BITS-1:0] sample_row3;
  logic [bcr_pkg::FRAC_BITS-1:0]   frac_vertical;
  logic [bcr_pkg::FRAC_BITS-1:0]   frac_horizontal;

  modport source (
    output valid, sample_row0, sample_row1, sample_row2, sample_row3,
           frac_vertical, frac_horizontal,
    input  ready
  );
  modport sink (
    input  valid, sample_row0, sample_row1, sample_row2, sample_row3,
           frac_vertical, frac_horizontal,
    output ready
  );
endinterface

interface bcr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bcr_pkg::OUT_BITS-1:0] interpolated;

  modport source (output valid, interpolated, input ready);
  modport sink (input valid, interpolated, output ready);
endinterface

FILE: rtl/bicubic_catmull_rom_interpolator.sv
// Catmull-Rom bicubic interpolator over a 4x4 window.
// in_i carries one column per transfer: four vertical samples (unsigned
// Q20.12) and the vertical and horizontal offsets (Q0.12). Each column is
// reduced to a partial by the cubic at frac_vertical; the fourth column's
// transfer also runs the cubic across the four partials at frac_horizontal
// and places the result (signed Q22.12) on out_o.
// One shared multiply unit evaluates the cubic in horner form, alternating
// an add and a multiply cycle, so a column occupies the block until its
// pass is done: in_i.ready drops after a transfer and returns only when the
// block is idle again, so it takes no new column while one is in work.
// On the fourth column the horizontal pass follows the vertical one, and the
// result is valid once that pass ends and the output register is free.
// The result waits in an output register; a stalled receiver does not stop
// the first three columns of the next window, and only the final pass of
// that window holds until the register is free.
// Reset clears the column count and the output valid; the block then
// expects the first column of a window.
module bicubic_catmull_rom_interpolator (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcr_in_if.sink     in_i,
  bcr_out_if.source  out_o
);

  bcr_pkg::bcr_cmd_t cmd;
  bcr_pkg::bcr_sts_t sts;

  bcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bcr_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .sample_row0_i     (in_i.sample_row0),
    .sample_row1_i     (in_i.sample_row1),
    .sample_row2_i     (in_i.sample_row2),
    .sample_row3_i     (in_i.sample_row3),
    .frac_vertical_i   (in_i.frac_vertical),
    .frac_horizontal_i (in_i.frac_horizontal),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .interpolated_o    (out_o.interpolated)
  );

  a_busy_after_transfer: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready
  ) else $error("input accepted while a column is in work");

  a_out_from_write: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.write_out)
  ) else $error("result appeared without a final pass");

  a_no_overwrite: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.write_out |-> !sts.out_full
  ) else $error("pending result overwritten");

  a_part_index: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.store_part |-> (cmd.part_idx != bcr_pkg::IDX_BITS'(bcr_pkg::COLS - 1))
  ) else $error("partial stored for the last column");

endmodule

FILE: rtl/bcr_datapath.sv
module bcr_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bcr_pkg::bcr_cmd_t                    cmd_i,
  output bcr_pkg::bcr_sts_t                    sts_o,
  input  logic [bcr_pkg::SAMPLE_BITS-1:0]      sample_row0_i,
  input  logic [bcr_pkg::SAMPLE_BITS-1:0]      sample_row1_i,
  input  logic [bcr_pkg::SAMPLE_BITS-1:0]      sample_row2_i,
  input  logic [bcr_pkg::SAMPLE_BITS-1:0]      sample_row3_i,
  input  logic [bcr_pkg::FRAC_BITS-1:0]        frac_vertical_i,
  input  logic [bcr_pkg::FRAC_BITS-1:0]        frac_horizontal_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [bcr_pkg::OUT_BITS-1:0]  interpolated_o
);

  localparam int A = bcr_pkg::ACC_BITS;
  localparam int O = bcr_pkg::OUT_BITS;
  localparam int P = bcr_pkg::PROD_BITS;
  localparam int F = bcr_pkg::FRAC_BITS;

  logic signed [A-1:0] q_q [bcr_pkg::COLS];
  logic signed [O-1:0] part_q [bcr_pkg::COLS-1];
  logic [F-1:0]        t_q;
  logic [F-1:0]        tx_q;
  logic signed [A-1:0] b_q, c_q, op_q, h_q;
  logic signed [O-1:0] out_q;
  logic                out_valid_q;

  logic signed [A-1:0] a_d, b_d, c_d;
  logic signed [P-1:0] prod;
  logic signed [A-1:0] p_full;
  logic signed [O-1:0] p_sat;
  logic                p_ovf;

  // cubic coefficients
  assign a_d = (q_q[1] <<< 1) + q_q[1] - (q_q[2] <<< 1) - q_q[2] + q_q[3] - q_q[0];
  assign b_d = (q_q[0] <<< 1) - (q_q[1] <<< 2) - q_q[1] + (q_q[2] <<< 2) - q_q[3];
  assign c_d = q_q[2] - q_q[0];

  assign prod = P'(op_q) * P'($signed({1'b0, t_q}));

  // final sum and saturation to the output range
  assign p_full = q_q[1] + (h_q >>> 1);
  assign p_ovf  = (p_full[A-1:O-1] != {(A-O+1){1'b0}}) &&
                  (p_full[A-1:O-1] != {(A-O+1){1'b1}});
  always_comb begin
    if (!p_ovf) begin
      p_sat = p_full[O-1:0];
    end else if (p_full[A-1]) begin
      p_sat = {1'b1, {(O-1){1'b0}}};
    end else begin
      p_sat = {1'b0, {(O-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      q_q[0] <= A'(sample_row0_i);
      q_q[1] <= A'(sample_row1_i);
      q_q[2] <= A'(sample_row2_i);
      q_q[3] <= A'(sample_row3_i);
      t_q    <= frac_vertical_i;
      tx_q   <= frac_horizontal_i;
    end else if (cmd_i.load_part) begin
      q_q[0] <= A'(part_q[0]);
      q_q[1] <= A'(part_q[1]);
      q_q[2] <= A'(part_q[2]);
      q_q[3] <= A'(p_sat);
      t_q    <= tx_q;
    end
    if (cmd_i.coef) begin
      b_q  <= b_d;
      c_q  <= c_d;
      op_q <= a_d;
    end else if (cmd_i.add_b) begin
      op_q <= h_q + b_q;
    end else if (cmd_i.add_c) begin
      op_q <= h_q + c_q;
    end
    if (cmd_i.coef) begin
      h_q <= '0;
    end else if (cmd_i.mul) begin
      h_q <= A'(prod >>> F);
    end
    if (cmd_i.store_part) begin
      case (cmd_i.part_idx)
        2'd0:    part_q[0] <= p_sat;
        2'd1:    part_q[1] <= p_sat;
        2'd2:    part_q[2] <= p_sat;
        default: ;
      endcase
    end
    if (cmd_i.write_out) begin
      out_q <= p_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.write_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign interpolated_o = out_q;
  assign sts_o.out_full = out_valid_q;

endmodule

FILE: rtl/bcr_ctrl.sv
module bcr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bcr_pkg::bcr_sts_t sts_i,
  output bcr_pkg::bcr_cmd_t cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StCoef = 3'd1;
  localparam logic [2:0] StMul1 = 3'd2;
  localparam logic [2:0] StAddB = 3'd3;
  localparam logic [2:0] StMul2 = 3'd4;
  localparam logic [2:0] StAddC = 3'd5;
  localparam logic [2:0] StMul3 = 3'd6;
  localparam logic [2:0] StFin  = 3'd7;

  localparam logic [bcr_pkg::IDX_BITS-1:0] LastCol = bcr_pkg::IDX_BITS'(bcr_pkg::COLS - 1);

  logic [2:0]                   state_q, state_d;
  logic [bcr_pkg::IDX_BITS-1:0] count_q, count_d;
  logic                         horiz_q, horiz_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    horiz_d = horiz_q;
    cmd_o   = '0;
    cmd_o.part_idx = count_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = StCoef;
        end
      end
      StCoef: begin
        cmd_o.coef = 1'b1;
        state_d = StMul1;
      end
      StMul1: begin
        cmd_o.mul = 1'b1;
        state_d = StAddB;
      end
      StAddB: begin
        cmd_o.add_b = 1'b1;
        state_d = StMul2;
      end
      StMul2: begin
        cmd_o.mul = 1'b1;
        state_d = StAddC;
      end
      StAddC: begin
        cmd_o.add_c = 1'b1;
        state_d = StMul3;
      end
      StMul3: begin
        cmd_o.mul = 1'b1;
        state_d = StFin;
      end
      StFin: begin
        if (horiz_q) begin
          if (!sts_i.out_full) begin
            cmd_o.write_out = 1'b1;
            count_d = '0;
            horiz_d = 1'b0;
            state_d = StIdle;
          end
        end else if (count_q == LastCol) begin
          cmd_o.load_part = 1'b1;
          horiz_d = 1'b1;
          state_d = StCoef;
        end else begin
          cmd_o.store_part = 1'b1;
          count_d = count_q + 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      horiz_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      horiz_q <= horiz_d;
    end
  end

endmodule

FILE: tb/sv/bicubic_catmull_rom_interpolator_tb.sv
module bicubic_catmull_rom_interpolator_tb;
  import bcr_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] S_MAX = '1;

  typedef struct packed {
    logic [3:0][SAMPLE_BITS-1:0] rows;
    logic [FRAC_BITS-1:0]        frac_v;
    logic [FRAC_BITS-1:0]        frac_h;
  } column_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bcr_in_if  in_bus ();
  bcr_out_if out_bus ();

  bicubic_catmull_rom_interpolator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  longint window_partials [3];
  int     window_col;

  logic [OUT_BITS-1:0] interp_expected_q [$];
  logic [OUT_BITS-1:0] interp_head;
  int                  mismatch_count;
  int                  sender_idle_pct;
  int                  receiver_stall_pct;

  column_t             dir_cols  [$];
  bit                  dir_known [$];
  logic [OUT_BITS-1:0] dir_value [$];

  function automatic longint clamp_out(input longint x);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (OUT_BITS - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic longint frac_scale(input longint x, input longint t);
    return (x * t) >>> FRAC_BITS;
  endfunction

  function automatic longint catmull_rom_eval(input longint q0, input longint q1,
                                              input longint q2, input longint q3,
                                              input longint t);
    longint a;
    longint b;
    longint c;
    longint h;
    a = -q0 + 3 * q1 - 3 * q2 + q3;
    b = 2 * q0 - 5 * q1 + 4 * q2 - q3;
    c = q2 - q0;
    h = frac_scale(a, t);
    h = frac_scale(h + b, t);
    h = frac_scale(h + c, t);
    return clamp_out(q1 + (h >>> 1));
  endfunction

  function automatic bit predict_column(input column_t col,
                                        output logic [OUT_BITS-1:0] value);
    longint p;
    longint r;
    p = catmull_rom_eval(longint'(col.rows[0]), longint'(col.rows[1]),
                         longint'(col.rows[2]), longint'(col.rows[3]),
                         longint'(col.frac_v));
    value = '0;
    if (window_col < 3) begin
      window_partials[window_col] = p;
      window_col++;
      return 1'b0;
    end
    r = catmull_rom_eval(window_partials[0], window_partials[1], window_partials[2], p,
                         longint'(col.frac_h));
    window_col = 0;
    value = r[OUT_BITS-1:0];
    return 1'b1;
  endfunction

  function automatic column_t mk_col(input logic [SAMPLE_BITS-1:0] s0,
                                     input logic [SAMPLE_BITS-1:0] s1,
                                     input logic [SAMPLE_BITS-1:0] s2,
                                     input logic [SAMPLE_BITS-1:0] s3,
                                     input logic [FRAC_BITS-1:0] fv,
                                     input logic [FRAC_BITS-1:0] fh);
    column_t c;
    c.rows[0] = s0;
    c.rows[1] = s1;
    c.rows[2] = s2;
    c.rows[3] = s3;
    c.frac_v  = fv;
    c.frac_h  = fh;
    return c;
  endfunction

  function automatic void add_row(input column_t c, input bit known,
                                  input logic [OUT_BITS-1:0] v);
    dir_cols.push_back(c);
    dir_known.push_back(known);
    dir_value.push_back(v);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_sample(input logic [SAMPLE_BITS-1:0] base);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return S_MAX;
      2, 3, 4: return $urandom();
      default: return base + SAMPLE_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [FRAC_BITS-1:0] rand_frac();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return FRAC_BITS'($urandom_range(0, (1 << FRAC_BITS) - 1));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_column(input column_t col, input bit known,
                             input logic [OUT_BITS-1:0] typed);
    logic [OUT_BITS-1:0] predicted;
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid           <= 1'b1;
    in_bus.sample_row0     <= col.rows[0];
    in_bus.sample_row1     <= col.rows[1];
    in_bus.sample_row2     <= col.rows[2];
    in_bus.sample_row3     <= col.rows[3];
    in_bus.frac_vertical   <= col.frac_v;
    in_bus.frac_horizontal <= col.frac_h;
    do @(posedge clk_i); while (!in_bus.ready);
    if (predict_column(col, predicted)) begin
      interp_expected_q.push_back(known ? typed : predicted);
    end
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (interp_expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_bus.interpolated));
      end else begin
        interp_head = interp_expected_q.pop_front();
        if (out_bus.interpolated !== interp_head) begin
          report_mismatch($sformatf("interpolated %h, expected %h",
                                    out_bus.interpolated, interp_head));
        end
      end
    end
  end

  initial begin
    column_t             col;
    logic [SAMPLE_BITS-1:0] base;
    int                  waited;
    int                  idle_set  [4];
    int                  stall_set [4];

    idle_set  = '{0, 48, 0, 19};
    stall_set = '{0, 0, 48, 19};
    mismatch_count         = 0;
    window_col             = 0;
    window_partials        = '{0, 0, 0};
    sender_idle_pct        = 0;
    receiver_stall_pct     = 0;
    base                   = '0;
    rst_ni                 = 1'b0;
    out_bus.ready          = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.sample_row0     = '0;
    in_bus.sample_row1     = '0;
    in_bus.sample_row2     = '0;
    in_bus.sample_row3     = '0;
    in_bus.frac_vertical   = '0;
    in_bus.frac_horizontal = '0;

    // flat windows hold their value, zero offsets pick the base sample
    repeat (3) add_row(mk_col('0, '0, '0, '0, 12'd4095, 12'd2048), 1'b0, '0);
    add_row(mk_col('0, '0, '0, '0, 12'd4095, 12'd2048), 1'b1, '0);
    repeat (3) add_row(mk_col(S_MAX, S_MAX, S_MAX, S_MAX, 12'd4095, 12'd4095), 1'b0, '0);
    add_row(mk_col(S_MAX, S_MAX, S_MAX, S_MAX, 12'd4095, 12'd4095), 1'b1, 35'h0FFFFFFFF);
    add_row(mk_col(32'h1, 32'h1000, S_MAX, '0, '0, '0), 1'b0, '0);
    add_row(mk_col(S_MAX, 32'h12345678, '0, S_MAX, '0, '0), 1'b0, '0);
    add_row(mk_col('0, S_MAX, 32'hAAAAAAAA, 32'h55555555, '0, '0), 1'b0, '0);
    add_row(mk_col(32'h55555555, '0, 32'h80000000, 32'h7FFFFFFF, '0, '0),
            1'b1, 35'h012345678);
    // overshoot below zero and above the sample range
    repeat (2) begin
      add_row(mk_col(S_MAX, '0, '0, S_MAX, 12'd2048, 12'd2048), 1'b0, '0);
      add_row(mk_col('0, S_MAX, S_MAX, '0, 12'd2048, 12'd2048), 1'b0, '0);
    end
    add_row(mk_col(S_MAX, S_MAX, '0, '0, 12'd1, 12'd4095), 1'b0, '0);
    add_row(mk_col('0, '0, S_MAX, S_MAX, 12'd4095, 12'd1), 1'b0, '0);
    add_row(mk_col(32'h80000000, 32'h7FFFFFFF, 32'h0000FFFF, 32'hFFFF0000, 12'h800, 12'h7FF),
            1'b0, '0);
    add_row(mk_col('0, S_MAX, '0, S_MAX, 12'hAAA, 12'h555), 1'b0, '0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < dir_cols.size(); i++) begin
      send_column(dir_cols[i], dir_known[i], dir_value[i]);
    end

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct    = idle_set[ph];
      receiver_stall_pct = stall_set[ph];
      repeat (150) begin
        if (window_col == 0) base = $urandom();
        col = mk_col(rand_sample(base), rand_sample(base), rand_sample(base),
                     rand_sample(base), rand_frac(), rand_frac());
        send_column(col, 1'b0, '0);
      end
    end
    in_bus.valid <= 1'b0;

    waited = 0;
    while (interp_expected_q.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (50) @(posedge clk_i);
    if (interp_expected_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", interp_expected_q.size()));
    end

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule
